/* hw/rtl/uv_sphere_vertex_generator_macros.svh */
// Assertion macros shared by the vertex generator RTL.
// No dependencies; included by the modules that carry checks.
`ifndef UV_SPHERE_VERTEX_GENERATOR_MACROS_SVH
`define UV_SPHERE_VERTEX_GENERATOR_MACROS_SVH

// same-cycle implication, disabled in reset
`define USVG_ASSERT_IMPL(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, disabled in reset
`define USVG_ASSERT_NEXT(name, clk, rst, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/usvg_pkg.sv */
// Types, constants and helpers for the UV sphere vertex generator.
// No dependencies; used by every RTL module of the block.
`default_nettype none

package usvg_pkg;

  // quotient pipeline geometry: 10-bit divisor (up to 2n), 30 quotient bits
  localparam int DVS_W = 10;
  localparam int QUO_W = 30;
  localparam int DVD_W = DVS_W + QUO_W;

  // back pipeline stage numbers
  localparam int SC_LAT  = 8;
  localparam int ST_DIV  = QUO_W;
  localparam int ST_SC   = ST_DIV + SC_LAT;
  localparam int BK_LAST = ST_SC + 3;

  // item queue between front and back
  localparam int FQ_DEPTH = 4;
  localparam int FQ_PTR_W = 2;
  localparam int FQ_CNT_W = 3;

  localparam logic [29:0] QPI_Q30       = 30'd843314857;  // pi/4
  localparam logic [29:0] INV_SQRT2_Q30 = 30'd759250125;
  localparam logic [30:0] Q30_ONE       = 31'h4000_0000;
  localparam logic [13:0] NORM_W_Q14    = 14'd11585;

  // exact reciprocal multipliers for 30-bit dividends: floor(v/d) = (v*M) >> S
  localparam int DIV42_S = 36;
  localparam int DIV56_S = 36;
  localparam int DIV20_S = 35;
  localparam int DIV30_S = 35;
  localparam int DIV6_S  = 33;
  localparam int DIV12_S = 34;
  localparam logic [30:0] DIV42_M = 31'(((64'd1 << DIV42_S) + 64'd41) / 64'd42);
  localparam logic [30:0] DIV56_M = 31'(((64'd1 << DIV56_S) + 64'd55) / 64'd56);
  localparam logic [30:0] DIV20_M = 31'(((64'd1 << DIV20_S) + 64'd19) / 64'd20);
  localparam logic [30:0] DIV30_M = 31'(((64'd1 << DIV30_S) + 64'd29) / 64'd30);
  localparam logic [30:0] DIV6_M  = 31'(((64'd1 << DIV6_S) + 64'd5) / 64'd6);
  localparam logic [30:0] DIV12_M = 31'(((64'd1 << DIV12_S) + 64'd11) / 64'd12);

  typedef struct packed {
    logic [2:0] oct;
    logic [9:0] rem;
  } oct_t;

  typedef struct packed {
    logic [8:0]  col;
    logic [8:0]  row;
    oct_t        th;
    oct_t        ph;
    logic        on_grid;
    logic        cell_valid;
    logic [16:0] vertex_index;
    logic [16:0] face_index;
  } fq_t;

  // octant of the angle a/(8q) turns, offset mirrored on odd octants
  function automatic oct_t oct_reduce(input logic [11:0] a, input logic [9:0] q);
    logic [13:0] r;
    logic [13:0] qs;
    logic [3:0]  o;
    oct_t        res;
    r = {2'b00, a};
    o = '0;
    for (int b = 3; b >= 0; b--) begin
      qs = {4'b0000, q} << b;
      if (r >= qs) begin
        r    = r - qs;
        o[b] = 1'b1;
      end
    end
    res.oct = o[2:0];
    res.rem = o[0] ? (q - r[9:0]) : r[9:0];
    return res;
  endfunction

  // Q30 product rounding, half up
  function automatic logic [30:0] rnd_q30(input logic [61:0] p);
    logic [62:0] t;
    t = {1'b0, p} + 63'(64'd1 << 29);
    return t[60:30];
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/usvg_front.sv */
// Front stage: takes a grid point, classifies it and reduces both angles
// to an octant. Depends on usvg_pkg.
`default_nettype none

module usvg_front (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic [8:0]     n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire logic [8:0]     col,
  input  wire logic [8:0]     row,
  output logic                out_valid,
  input  wire logic           out_ready,
  output usvg_pkg::fq_t       out_item
);

  logic          held;
  usvg_pkg::fq_t item;
  usvg_pkg::fq_t item_next;

  logic [8:0]  p_phi;
  logic [18:0] vtx;
  logic [18:0] fc;

  assign in_ready  = !held || out_ready;
  assign out_valid = held;
  assign out_item  = item;

  always_comb begin
    p_phi = n - row;
    vtx   = 19'({1'b0, n} + 10'd1) * 19'(row) + 19'(col);
    fc    = 19'(n) * 19'(row) + 19'(col);
    item_next.col          = col;
    item_next.row          = row;
    item_next.th           = usvg_pkg::oct_reduce({col, 3'b000}, {1'b0, n});
    item_next.ph           = usvg_pkg::oct_reduce({p_phi, 3'b000}, {n, 1'b0});
    item_next.on_grid      = (col <= n) && (row <= n);
    item_next.cell_valid   = (col < n) && (row < n);
    item_next.vertex_index = item_next.on_grid ? vtx[16:0] : 17'd0;
    item_next.face_index   = item_next.cell_valid ? {fc[15:0], 1'b0} : 17'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_ready) begin
      held <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      item <= item_next;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/usvg_fifo.sv */
// Short item queue between front and back stages.
// Depends on usvg_pkg and the assertion macro header.
`default_nettype none
`include "uv_sphere_vertex_generator_macros.svh"

module usvg_fifo (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push_valid,
  output logic                push_ready,
  input  wire usvg_pkg::fq_t  push_item,
  output logic                pop_valid,
  input  wire logic           pop_ready,
  output usvg_pkg::fq_t       pop_item
);

  usvg_pkg::fq_t                     slots [usvg_pkg::FQ_DEPTH];
  logic [usvg_pkg::FQ_PTR_W-1:0]     wr_ptr;
  logic [usvg_pkg::FQ_PTR_W-1:0]     rd_ptr;
  logic [usvg_pkg::FQ_CNT_W-1:0]     count;
  logic                              push;
  logic                              pop;

  assign push_ready = (count != usvg_pkg::FQ_CNT_W'(usvg_pkg::FQ_DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_item   = slots[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  `USVG_ASSERT_IMPL(a_fq_bound, clk, rst, 1'b1, count <= usvg_pkg::FQ_CNT_W'(usvg_pkg::FQ_DEPTH), "queue count beyond depth")
  `USVG_ASSERT_NEXT(a_fq_fill, clk, rst, push && !pop, count == $past(count) + 1'b1, "queue fill lost an item")
  `USVG_ASSERT_NEXT(a_fq_drain, clk, rst, pop && !push, count == $past(count) - 1'b1, "queue drain miscounted")

endmodule

`default_nettype wire

/* hw/rtl/usvg_div.sv */
// Pipelined restoring divider, one quotient bit per stage.
// Depends on usvg_pkg; the dividend must be below divisor * 2^QUO_W.
`default_nettype none

module usvg_div (
  input  wire logic                        clk,
  input  wire logic                        en,
  input  wire logic [usvg_pkg::DVD_W-1:0]  dvd,
  input  wire logic [usvg_pkg::DVS_W-1:0]  dvs,
  output logic      [usvg_pkg::QUO_W-1:0]  quo
);

  // word = {partial remainder, dividend bits still to go / quotient bits so far}
  logic [usvg_pkg::DVD_W-1:0] stg [usvg_pkg::QUO_W];

  function automatic logic [usvg_pkg::DVD_W-1:0] step(
    input logic [usvg_pkg::DVD_W-1:0] w,
    input logic [usvg_pkg::DVS_W-1:0] d
  );
    logic [usvg_pkg::DVS_W:0]   t;
    logic                       ge;
    logic [usvg_pkg::DVS_W:0]   r;
    t  = w[usvg_pkg::DVD_W-1:usvg_pkg::QUO_W-1];
    ge = (t >= {1'b0, d});
    r  = ge ? (t - {1'b0, d}) : t;
    return {r[usvg_pkg::DVS_W-1:0], w[usvg_pkg::QUO_W-2:0], ge};
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      stg[0] <= step(dvd, dvs);
      for (int s = 1; s < usvg_pkg::QUO_W; s++) begin
        stg[s] <= step(stg[s-1], dvs);
      end
    end
  end

  assign quo = stg[usvg_pkg::QUO_W-1][usvg_pkg::QUO_W-1:0];

endmodule

`default_nettype wire

/* hw/rtl/usvg_sincos.sv */
// Eight-stage sine/cosine of a first-octant Q30 angle (Taylor series).
// Depends on usvg_pkg.
`default_nettype none

module usvg_sincos (
  input  wire logic        clk,
  input  wire logic        en,
  input  wire logic [29:0] x,
  output logic      [30:0] s,
  output logic      [30:0] c
);

  logic [29:0] x1, x2_, x3, x4, x5, x6;
  logic [29:0] sq2, sq3, sq4, sq5, sq6;
  logic [60:0] p1;
  logic [60:0] a2, b2, a3, b3, a4, b4, a5, b5, a6, b6, a7, b7;
  logic [30:0] sq_r, ra3, rb3, ra5, rb5;
  logic [30:0] t1, u1, t2, u2, t3, u3;

  always_comb begin
    sq_r = usvg_pkg::rnd_q30(62'(p1));
    t1   = usvg_pkg::Q30_ONE - 31'(a2 >> usvg_pkg::DIV42_S);
    u1   = usvg_pkg::Q30_ONE - 31'(b2 >> usvg_pkg::DIV56_S);
    ra3  = usvg_pkg::rnd_q30(62'(a3));
    rb3  = usvg_pkg::rnd_q30(62'(b3));
    t2   = usvg_pkg::Q30_ONE - 31'(a4 >> usvg_pkg::DIV20_S);
    u2   = usvg_pkg::Q30_ONE - 31'(b4 >> usvg_pkg::DIV30_S);
    ra5  = usvg_pkg::rnd_q30(62'(a5));
    rb5  = usvg_pkg::rnd_q30(62'(b5));
    t3   = usvg_pkg::Q30_ONE - 31'(a6 >> usvg_pkg::DIV6_S);
    u3   = usvg_pkg::Q30_ONE - 31'(b6 >> usvg_pkg::DIV12_S);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // x^2
      x1  <= x;
      p1  <= 61'(x) * 61'(x);
      // x^2/42, x^2/56
      x2_ <= x1;
      sq2 <= sq_r[29:0];
      a2  <= 61'(sq_r[29:0]) * 61'(usvg_pkg::DIV42_M);
      b2  <= 61'(sq_r[29:0]) * 61'(usvg_pkg::DIV56_M);
      // x^2 * t
      x3  <= x2_;
      sq3 <= sq2;
      a3  <= 61'(sq2) * 61'(t1);
      b3  <= 61'(sq2) * 61'(u1);
      // /20, /30
      x4  <= x3;
      sq4 <= sq3;
      a4  <= 61'(ra3[29:0]) * 61'(usvg_pkg::DIV20_M);
      b4  <= 61'(rb3[29:0]) * 61'(usvg_pkg::DIV30_M);
      x5  <= x4;
      sq5 <= sq4;
      a5  <= 61'(sq4) * 61'(t2);
      b5  <= 61'(sq4) * 61'(u2);
      // /6, /12
      x6  <= x5;
      sq6 <= sq5;
      a6  <= 61'(ra5[29:0]) * 61'(usvg_pkg::DIV6_M);
      b6  <= 61'(rb5[29:0]) * 61'(usvg_pkg::DIV12_M);
      // last terms
      a7  <= 61'(x6) * 61'(t3);
      b7  <= 61'(sq6) * 61'(u3);
      s   <= usvg_pkg::rnd_q30(62'(a7));
      c   <= usvg_pkg::Q30_ONE - (usvg_pkg::rnd_q30(62'(b7)) >> 1);
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/usvg_back.sv */
// Back pipeline: quotients, sine/cosine, sphere point, normal and output register.
// Depends on usvg_pkg, usvg_div, usvg_sincos and the assertion macro header.
`default_nettype none
`include "uv_sphere_vertex_generator_macros.svh"

module usvg_back (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic [8:0]         n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire usvg_pkg::fq_t      in_item,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [16:0]             vertex_index,
  output logic signed [15:0]      pos_x,
  output logic signed [15:0]      pos_y,
  output logic signed [15:0]      pos_z,
  output logic signed [14:0]      norm_x,
  output logic signed [14:0]      norm_y,
  output logic signed [14:0]      norm_z,
  output logic [13:0]             norm_w,
  output logic [14:0]             tex_u,
  output logic [14:0]             tex_v,
  output logic                    cell_valid,
  output logic [16:0]             face_index
);

  localparam int LAST  = usvg_pkg::BK_LAST;
  localparam int TEX_N = LAST - 1 - usvg_pkg::ST_DIV;

  typedef struct packed {
    logic [2:0]  oct_t;
    logic [2:0]  oct_p;
    logic        on_grid;
    logic        cell_valid;
    logic [16:0] vertex_index;
    logic [16:0] face_index;
  } side_t;

  typedef struct packed {
    logic [14:0] u;
    logic [14:0] v;
  } tex_t;

  typedef struct packed {
    logic        sn_neg;
    logic [30:0] sn;
    logic        cs_neg;
    logic [30:0] cs;
  } sc_t;

  logic                          adv;
  logic [LAST:0]                 vld;
  side_t                         side_d [LAST];
  tex_t                          tex_d  [TEX_N];

  logic [usvg_pkg::DVD_W-1:0]    dth, dph, du, dv;
  logic [usvg_pkg::QUO_W-1:0]    qth, qph, qu, qv;
  logic [30:0]                   s_t, c_t, s_p, c_p;
  sc_t                           ang_t, ang_p;

  logic [61:0]                   ppx, ppz;
  logic [30:0]                   my1;
  logic                          negx1, negy1, negz1;
  logic [30:0]                   mx2, my2, mz2;
  logic [60:0]                   pnx, pny, pnz;
  logic                          negx2, negy2, negz2;
  logic [30:0]                   mx_r, mz_r;
  logic [30:0]                   nx_r, ny_r, nz_r;
  logic [14:0]                   qpx, qpy, qpz, qnx, qny, qnz;

  function automatic sc_t oct_sel(input logic [2:0] o, input logic [30:0] sv,
                                  input logic [30:0] cv);
    sc_t r;
    r = '0;
    case (o)
      3'd0: r = '{1'b0, sv, 1'b0, cv};
      3'd1: r = '{1'b0, cv, 1'b0, sv};
      3'd2: r = '{1'b0, cv, 1'b1, sv};
      3'd3: r = '{1'b0, sv, 1'b1, cv};
      3'd4: r = '{1'b1, sv, 1'b1, cv};
      3'd5: r = '{1'b1, cv, 1'b1, sv};
      3'd6: r = '{1'b1, cv, 1'b0, sv};
      default: r = '{1'b1, sv, 1'b0, cv};
    endcase
    return r;
  endfunction

  // Q30 magnitude to Q1.14, half away from zero on the signed value
  function automatic logic [14:0] to_q14(input logic [30:0] m);
    logic [31:0] t;
    t = {1'b0, m} + 32'h0000_8000;
    return t[30:16];
  endfunction

  assign adv       = !vld[LAST] || out_ready;
  assign in_ready  = adv;
  assign out_valid = vld[LAST];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[LAST-1:0], in_valid};
    end
  end

  // stage 0: dividends
  always_ff @(posedge clk) begin
    if (adv) begin
      dth <= usvg_pkg::DVD_W'(usvg_pkg::QPI_Q30) * usvg_pkg::DVD_W'(in_item.th.rem)
             + usvg_pkg::DVD_W'(n[8:1]);
      dph <= usvg_pkg::DVD_W'(usvg_pkg::QPI_Q30) * usvg_pkg::DVD_W'(in_item.ph.rem)
             + usvg_pkg::DVD_W'(n);
      du  <= usvg_pkg::DVD_W'({in_item.col, 14'd0}) + usvg_pkg::DVD_W'(n[8:1]);
      dv  <= usvg_pkg::DVD_W'({in_item.row, 14'd0}) + usvg_pkg::DVD_W'(n[8:1]);
      side_d[0] <= '{in_item.th.oct, in_item.ph.oct, in_item.on_grid,
                     in_item.cell_valid, in_item.vertex_index, in_item.face_index};
      for (int k = 1; k < LAST; k++) begin
        side_d[k] <= side_d[k-1];
      end
      tex_d[0] <= '{qu[14:0], qv[14:0]};
      for (int k = 1; k < TEX_N; k++) begin
        tex_d[k] <= tex_d[k-1];
      end
    end
  end

  usvg_div u_div_th (.clk(clk), .en(adv), .dvd(dth), .dvs({1'b0, n}), .quo(qth));
  usvg_div u_div_ph (.clk(clk), .en(adv), .dvd(dph), .dvs({n, 1'b0}), .quo(qph));
  usvg_div u_div_u  (.clk(clk), .en(adv), .dvd(du),  .dvs({1'b0, n}), .quo(qu));
  usvg_div u_div_v  (.clk(clk), .en(adv), .dvd(dv),  .dvs({1'b0, n}), .quo(qv));

  usvg_sincos u_sc_th (.clk(clk), .en(adv), .x(qth), .s(s_t), .c(c_t));
  usvg_sincos u_sc_ph (.clk(clk), .en(adv), .x(qph), .s(s_p), .c(c_p));

  always_comb begin
    ang_t = oct_sel(side_d[usvg_pkg::ST_SC].oct_t, s_t, c_t);
    ang_p = oct_sel(side_d[usvg_pkg::ST_SC].oct_p, s_p, c_p);
    mx_r  = usvg_pkg::rnd_q30(ppx);
    mz_r  = usvg_pkg::rnd_q30(ppz);
    nx_r  = usvg_pkg::rnd_q30(62'(pnx));
    ny_r  = usvg_pkg::rnd_q30(62'(pny));
    nz_r  = usvg_pkg::rnd_q30(62'(pnz));
    qpx   = to_q14(mx2);
    qpy   = to_q14(my2);
    qpz   = to_q14(mz2);
    qnx   = to_q14(nx_r);
    qny   = to_q14(ny_r);
    qnz   = to_q14(nz_r);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      // sphere point products, sign and magnitude
      ppx   <= 62'(ang_p.sn) * 62'(ang_t.cs);
      ppz   <= 62'(ang_p.sn) * 62'(ang_t.sn);
      my1   <= ang_p.cs;
      negx1 <= ang_p.sn_neg ^ ang_t.cs_neg;
      negz1 <= ang_p.sn_neg ^ ang_t.sn_neg;
      negy1 <= ang_p.cs_neg;
      // 1/sqrt2 scaling
      mx2   <= mx_r;
      my2   <= my1;
      mz2   <= mz_r;
      pnx   <= 61'(mx_r) * 61'(usvg_pkg::INV_SQRT2_Q30);
      pny   <= 61'(my1) * 61'(usvg_pkg::INV_SQRT2_Q30);
      pnz   <= 61'(mz_r) * 61'(usvg_pkg::INV_SQRT2_Q30);
      negx2 <= negx1;
      negy2 <= negy1;
      negz2 <= negz1;
      // output register; points off the grid read as all zero
      vertex_index <= side_d[LAST-1].vertex_index;
      cell_valid   <= side_d[LAST-1].cell_valid;
      face_index   <= side_d[LAST-1].face_index;
      if (side_d[LAST-1].on_grid) begin
        pos_x  <= negx2 ? 16'(-{1'b0, qpx}) : {1'b0, qpx};
        pos_y  <= negy2 ? 16'(-{1'b0, qpy}) : {1'b0, qpy};
        pos_z  <= negz2 ? 16'(-{1'b0, qpz}) : {1'b0, qpz};
        norm_x <= negx2 ? 15'(-{1'b0, qnx[13:0]}) : {1'b0, qnx[13:0]};
        norm_y <= negy2 ? 15'(-{1'b0, qny[13:0]}) : {1'b0, qny[13:0]};
        norm_z <= negz2 ? 15'(-{1'b0, qnz[13:0]}) : {1'b0, qnz[13:0]};
        norm_w <= usvg_pkg::NORM_W_Q14;
        tex_u  <= tex_d[TEX_N-1].u;
        tex_v  <= tex_d[TEX_N-1].v;
      end else begin
        pos_x  <= '0;
        pos_y  <= '0;
        pos_z  <= '0;
        norm_x <= '0;
        norm_y <= '0;
        norm_z <= '0;
        norm_w <= '0;
        tex_u  <= '0;
        tex_v  <= '0;
      end
    end
  end

  `USVG_ASSERT_IMPL(a_bk_stall, clk, rst, vld[LAST] && !out_ready, !in_ready, "back took an item while output stalled")
  `USVG_ASSERT_IMPL(a_bk_face, clk, rst, out_valid && !cell_valid, face_index == 17'd0, "face index on an edge point")
  `USVG_ASSERT_IMPL(a_bk_normw, clk, rst, out_valid && cell_valid, norm_w == usvg_pkg::NORM_W_Q14, "normal w wrong on a cell")

endmodule

`default_nettype wire

/* hw/rtl/uv_sphere_vertex_generator.sv */
// Top level of the UV sphere vertex generator: segments register, front stage,
// item queue and back pipeline. Depends on usvg_pkg, usvg_front, usvg_fifo, usvg_back.
//
//   channel | signals                         | moves
//   --------+---------------------------------+-----------------------------------
//   cfg     | cfg_valid cfg_ready cfg_data    | segments write (always ready)
//   in      | in_valid in_ready col row       | one grid point item
//   out     | out_valid out_ready + 12 fields | one vertex item per grid point
//
// Sustained rate is one item per clock while out_ready stays high. An item passes
// the front register (loaded at the accepting edge), one queue slot, then 42 back
// stages, dominated by the 30 one-bit-per-stage quotient pipelines for the angles
// and texture coordinates, then 8 sine/cosine stages and 3 product/rounding stages.
// Reset (rst, synchronous) empties all stages and sets segments to 16; no clearing
// pass. An output stall freezes the back pipe; the 4-item queue and the front
// register keep taking items until they fill.
`default_nettype none

module uv_sphere_vertex_generator #(
  parameter int MAX_SEGMENTS = 256
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [8:0]         cfg_data,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic [8:0]         col,
  input  wire logic [8:0]         row,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [16:0]             vertex_index,
  output logic signed [15:0]      pos_x,
  output logic signed [15:0]      pos_y,
  output logic signed [15:0]      pos_z,
  output logic signed [14:0]      norm_x,
  output logic signed [14:0]      norm_y,
  output logic signed [14:0]      norm_z,
  output logic [13:0]             norm_w,
  output logic [14:0]             tex_u,
  output logic [14:0]             tex_v,
  output logic                    cell_valid,
  output logic [16:0]             face_index
);

  // clamp limit; values at or above 512 never bind on a 9-bit write
  localparam logic [10:0] MAX_W     = 11'(MAX_SEGMENTS);
  localparam logic [8:0]  SEG_RESET = (MAX_W < 11'd16) ? MAX_W[8:0] : 9'd16;

  // segments is held already clamped to 1..MAX_SEGMENTS
  logic [8:0]     segments;
  logic [8:0]     segments_next;

  logic           fr_valid;
  logic           fr_ready;
  usvg_pkg::fq_t  fr_item;
  logic           bk_valid;
  logic           bk_ready;
  usvg_pkg::fq_t  bk_item;

  assign cfg_ready = 1'b1;

  always_comb begin
    if (cfg_data == 9'd0) begin
      segments_next = 9'd1;
    end else if ({2'b00, cfg_data} > MAX_W) begin
      segments_next = MAX_W[8:0];
    end else begin
      segments_next = cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      segments <= SEG_RESET;
    end else if (cfg_valid && cfg_ready) begin
      segments <= segments_next;
    end
  end

  // front: grid classification, indices, octant reduction
  usvg_front u_front (
    .clk       (clk),
    .rst       (rst),
    .n         (segments),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .col       (col),
    .row       (row),
    .out_valid (fr_valid),
    .out_ready (fr_ready),
    .out_item  (fr_item)
  );

  // decouples the front from back-pipe stalls
  usvg_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_valid (fr_valid),
    .push_ready (fr_ready),
    .push_item  (fr_item),
    .pop_valid  (bk_valid),
    .pop_ready  (bk_ready),
    .pop_item   (bk_item)
  );

  // back: divides, sine/cosine, point, normal, output register
  usvg_back u_back (
    .clk          (clk),
    .rst          (rst),
    .n            (segments),
    .in_valid     (bk_valid),
    .in_ready     (bk_ready),
    .in_item      (bk_item),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .vertex_index (vertex_index),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .pos_z        (pos_z),
    .norm_x       (norm_x),
    .norm_y       (norm_y),
    .norm_z       (norm_z),
    .norm_w       (norm_w),
    .tex_u        (tex_u),
    .tex_v        (tex_v),
    .cell_valid   (cell_valid),
    .face_index   (face_index)
  );

endmodule

`default_nettype wire

/* tb/tb_uv_sphere_vertex_generator.sv */
// Self-checking bench for the UV sphere vertex generator: random and directed grid
// points, segments changes between phases, output stalls. Depends on the RTL only.
`default_nettype none

module tb_uv_sphere_vertex_generator;

  typedef struct {
    logic [8:0] col;
    logic [8:0] row;
  } point_t;

  typedef struct {
    logic [16:0] vertex_index;
    logic [15:0] pos_x, pos_y, pos_z;
    logic [14:0] norm_x, norm_y, norm_z;
    logic [13:0] norm_w;
    logic [14:0] tex_u, tex_v;
    logic        cell_valid;
    logic [16:0] face_index;
  } vertex_t;

  localparam int          MAX_SEG   = 256;
  localparam int          PIPE_LAT  = 44;
  localparam logic [63:0] QPI       = 64'd843314857;
  localparam logic [63:0] RSQ2      = 64'd759250125;
  localparam logic [63:0] ONE_Q30   = 64'd1 << 30;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic [8:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic [8:0] col = '0, row = '0;
  logic out_ready = 1'b0;
  logic cfg_ready, in_ready, out_valid;
  vertex_t got;

  always #1 clk = ~clk;

  uv_sphere_vertex_generator u_top (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready), .col(col), .row(row),
    .out_valid(out_valid), .out_ready(out_ready),
    .vertex_index(got.vertex_index), .pos_x(got.pos_x), .pos_y(got.pos_y),
    .pos_z(got.pos_z), .norm_x(got.norm_x), .norm_y(got.norm_y),
    .norm_z(got.norm_z), .norm_w(got.norm_w), .tex_u(got.tex_u),
    .tex_v(got.tex_v), .cell_valid(got.cell_valid), .face_index(got.face_index)
  );

  // predictor copy of the segments register
  logic [8:0] seg_reg = 9'd16;

  point_t  pending_points[$];
  vertex_t expected_vertices[$];
  int      fail_count = 0;
  int      hold_left = 0;   // cycles of long output stall still to go
  bit      in_took = 1'b0;  // input item accepted at the last rising edge

  function automatic logic [63:0] mulq(input logic [63:0] a, input logic [63:0] b);
    return (a * b + (64'd1 << 29)) >> 30;
  endfunction

  // signed Q30 product, rounded on the magnitude
  function automatic longint smulq(input longint a, input longint b);
    logic [63:0] m;
    m = mulq(a < 0 ? -a : a, b < 0 ? -b : b);
    return ((a < 0) != (b < 0)) ? -longint'(m) : longint'(m);
  endfunction

  function automatic int q30_to_q14(input longint a);
    longint m;
    m = ((a < 0 ? -a : a) + (64'd1 << 15)) >> 16;
    return a < 0 ? -int'(m) : int'(m);
  endfunction

  function automatic bit field_ok(input string name, input logic [16:0] exp_v,
                                  input logic [16:0] got_v);
    if (exp_v !== got_v) begin
      $error("%s exp %0h got %0h", name, exp_v, got_v);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  // sine and cosine of p/q turns, signed Q30
  task automatic turn_sincos(input longint p, input longint q,
                             output longint sn, output longint cs);
    logic [63:0] a, oct, rem, x, x2, t, s, c;
    a   = 8 * p;
    oct = a / q;
    rem = a - oct * q;
    oct = oct & 7;
    if (oct[0]) rem = q - rem;
    x  = (QPI * rem + q / 2) / q;
    x2 = mulq(x, x);
    t = ONE_Q30 - x2 / 42;
    t = ONE_Q30 - mulq(x2, t) / 20;
    t = ONE_Q30 - mulq(x2, t) / 6;
    s = mulq(x, t);
    t = ONE_Q30 - x2 / 56;
    t = ONE_Q30 - mulq(x2, t) / 30;
    t = ONE_Q30 - mulq(x2, t) / 12;
    c = ONE_Q30 - mulq(x2, t) / 2;
    case (oct)
      0: begin sn = s;  cs = c;  end
      1: begin sn = c;  cs = s;  end
      2: begin sn = c;  cs = -s; end
      3: begin sn = s;  cs = -c; end
      4: begin sn = -s; cs = -c; end
      5: begin sn = -c; cs = -s; end
      6: begin sn = -c; cs = s;  end
      default: begin sn = -s; cs = c; end
    endcase
  endtask

  task automatic predict_vertex(input point_t pt);
    longint n, st, ct, sp, cp, px, py, pz;
    vertex_t v;
    n = seg_reg;
    if (n < 1) n = 1;          // zero acts as one
    if (n > MAX_SEG) n = MAX_SEG;
    v = '{default: '0};
    if (pt.col <= n && pt.row <= n) begin
      turn_sincos(pt.col, n, st, ct);
      turn_sincos(n - pt.row, 2 * n, sp, cp);
      px = smulq(sp, ct);
      py = cp;
      pz = smulq(sp, st);
      v.vertex_index = 17'((n + 1) * pt.row + pt.col);
      v.pos_x  = 16'(q30_to_q14(px));
      v.pos_y  = 16'(q30_to_q14(py));
      v.pos_z  = 16'(q30_to_q14(pz));
      v.norm_x = 15'(q30_to_q14(smulq(px, RSQ2)));
      v.norm_y = 15'(q30_to_q14(smulq(py, RSQ2)));
      v.norm_z = 15'(q30_to_q14(smulq(pz, RSQ2)));
      v.norm_w = 14'd11585;
      v.tex_u  = 15'((pt.col * 16384 + n / 2) / n);
      v.tex_v  = 15'((pt.row * 16384 + n / 2) / n);
      v.cell_valid = (pt.col < n) && (pt.row < n);
      v.face_index = v.cell_valid ? 17'(2 * (n * pt.row + pt.col)) : '0;
    end
    expected_vertices.insert(expected_vertices.size(), v);
  endtask

  // input handshake as seen at the rising edge
  always @(posedge clk) begin
    in_took = !rst && in_valid && in_ready;
  end

  // driver: bursts of random length, random gaps between them
  int burst_left = 0, gap_left = 0;
  always @(negedge clk) begin
    if (!rst) begin
      if (in_took) begin
        // accepted at the last rising edge: predict, then move on
        predict_vertex(pending_points.pop_front());
      end
      if (!in_valid || in_took) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_points.size() > 0) begin
          in_valid <= 1'b1;
          col <= pending_points[0].col;
          row <= pending_points[0].row;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
          end
          burst_left--;
          if (burst_left == 0 && $urandom_range(0, 2) != 0) begin
            gap_left = $urandom_range(1, 8);
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall pattern: phases of free flow, light and heavy stalls
  int stall_mode = 0, mode_left = 0;
  always @(negedge clk) begin
    if (mode_left == 0) begin
      stall_mode = $urandom_range(0, 2);
      mode_left = $urandom_range(20, 200);
    end
    mode_left--;
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      case (stall_mode)
        0: out_ready <= 1'b1;
        1: out_ready <= ($urandom_range(0, 3) != 0);
        default: out_ready <= ($urandom_range(0, 3) == 0);
      endcase
    end
  end

  // monitor
  always @(posedge clk) begin
    vertex_t e;
    bit      ok;
    if (!rst && out_valid && out_ready) begin
      if (expected_vertices.size() == 0) begin
        $error("vertex item with nothing expected");
        fail_count++;
      end else begin
        e = expected_vertices.pop_front();
        ok = 1'b1;
        ok &= field_ok("vertex_index", e.vertex_index, got.vertex_index);
        ok &= field_ok("pos_x", 17'(e.pos_x), 17'(got.pos_x));
        ok &= field_ok("pos_y", 17'(e.pos_y), 17'(got.pos_y));
        ok &= field_ok("pos_z", 17'(e.pos_z), 17'(got.pos_z));
        ok &= field_ok("norm_x", 17'(e.norm_x), 17'(got.norm_x));
        ok &= field_ok("norm_y", 17'(e.norm_y), 17'(got.norm_y));
        ok &= field_ok("norm_z", 17'(e.norm_z), 17'(got.norm_z));
        ok &= field_ok("norm_w", 17'(e.norm_w), 17'(got.norm_w));
        ok &= field_ok("tex_u", 17'(e.tex_u), 17'(got.tex_u));
        ok &= field_ok("tex_v", 17'(e.tex_v), 17'(got.tex_v));
        ok &= field_ok("cell_valid", 17'(e.cell_valid), 17'(got.cell_valid));
        ok &= field_ok("face_index", e.face_index, got.face_index);
        if (!ok) fail_count++;
      end
    end
  end

  // wait until the block is empty and every expectation is met
  task automatic drain();
    while (pending_points.size() > 0 || in_valid || expected_vertices.size() > 0)
      @(negedge clk);
    repeat (PIPE_LAT + 4) @(negedge clk);
  endtask

  task automatic write_segments(input logic [8:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    seg_reg = value;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  function automatic void add_point(input int c, input int r);
    point_t p;
    p.col = 9'(c);
    p.row = 9'(r);
    pending_points.insert(pending_points.size(), p);
  endfunction

  // mostly in-grid points, some just outside, a few anywhere
  task automatic random_points(input int count);
    int n;
    n = (seg_reg == 0) ? 1 : (seg_reg > MAX_SEG ? MAX_SEG : seg_reg);
    for (int k = 0; k < count; k++) begin
      case ($urandom_range(0, 9))
        0: add_point($urandom_range(0, 511), $urandom_range(0, 511));
        1: add_point(n + $urandom_range(0, 2), $urandom_range(0, n));
        2: add_point($urandom_range(0, n), n + $urandom_range(0, 2));
        default: add_point($urandom_range(0, n), $urandom_range(0, n));
      endcase
    end
  endtask

  // segments settings per random phase: extremes plus random values
  logic [8:0] phase_segs[8] = '{9'd16, 9'd1, 9'd256, 9'd0, 9'd511, 9'd257, 9'd7, 9'd100};

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: corners, poles, seam, points outside the grid at reset segments
    add_point(0, 0);    add_point(16, 16);  add_point(0, 16);   add_point(16, 0);
    add_point(8, 8);    add_point(4, 12);   add_point(15, 15);  add_point(17, 0);
    add_point(0, 17);   add_point(511, 511); add_point(3, 1);   add_point(12, 5);
    drain();
    // extremes of segments with their corner points
    write_segments(9'd256);
    add_point(256, 256); add_point(255, 255); add_point(0, 256); add_point(128, 64);
    add_point(257, 3);
    drain();
    write_segments(9'd0);
    add_point(0, 0); add_point(1, 1); add_point(1, 0); add_point(2, 0);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      write_segments(ph == 7 ? 9'($urandom_range(2, 255)) : phase_segs[ph]);
      random_points(125);
      if (ph == 2) begin
        // long output stall while items keep coming: the input must back up
        hold_left = 300;
      end
      drain();
    end

    if (fail_count == 0) begin
      $display("uv_sphere_vertex_generator: match");
    end else begin
      $display("uv_sphere_vertex_generator: mismatch");
    end
    $finish;
  end

  initial begin
    #400000;
    $display("uv_sphere_vertex_generator: mismatch");
    $finish;
  end

endmodule

`default_nettype wire
